// ===== src/e2q_pkg.sv =====
// e2q_pkg: shared constants, field layout and sine table helpers for the
// euler to quaternion pipeline. No dependencies.
package e2q_pkg;

  // beat layout on the input stream
  localparam int PITCH_W    = 16;
  localparam int YAW_W      = 15;
  localparam int ROLL_W     = 16;
  localparam int PITCH_LSB  = 0;
  localparam int YAW_LSB    = PITCH_LSB + PITCH_W;
  localparam int ROLL_LSB   = YAW_LSB + YAW_W;
  localparam int IN_DATA_W  = 48;

  // beat layout on the output stream
  localparam int QUAT_W     = 16;
  localparam int OUT_DATA_W = 4 * QUAT_W;

  // angle lanes
  localparam int NUM_LANES  = 3;
  localparam int LANE_X     = 0;
  localparam int LANE_Y     = 1;
  localparam int LANE_Z     = 2;

  // clamp limits in hundredths of a degree
  localparam int PITCH_LIMIT = 18000;
  localparam int YAW_LIMIT   = 9000;
  localparam int ROLL_LIMIT  = 18000;
  localparam int MAG_W       = 15;

  // index = floor((mag * depth + 9000) / 18000), with 18000 = 16 * 1125
  localparam int IDX_ROUND     = 9000;
  localparam int IDX_DIVISOR   = 18000;
  localparam int IDX_PRE_SHIFT = 4;
  localparam int IDX_ODD_DIV   = 1125;

  // sine table generation in unsigned Q2.62
  localparam int          Q_FRAC       = 62;
  localparam int          TAYLOR_TERMS = 10;
  localparam logic [63:0] HALF_PI_Q62  = 64'h6487ED5110B4611A;
  localparam logic [63:0] TAYLOR_DIV [1:TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
    64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  // Q2.62 product, truncated
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[Q_FRAC +: 64];
  endfunction

  // taylor series for sin(x), x in Q2.62, result before rounding
  function automatic logic [63:0] sine_q62(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = mul_q62(term, x2) / TAYLOR_DIV[n];
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

endpackage

// ===== src/euler_to_quaternion_top.sv =====
// euler_to_quaternion_top: euler angles (hundredths of a degree) to a unit
// quaternion in fixed point, eight register stages. Depends on e2q_pkg.
//
//  channel  | dir | beat contents
//  ---------+-----+-----------------------------------------------------
//  s_axis   | in  | pitch_angle, yaw_angle, roll_angle (one pose)
//  m_axis   | out | quat_w, quat_x, quat_y, quat_z (one quaternion)
//
// one beat in per clock while m_axis does not stall; the depth is set by the
// clamp, index divider, table read, pair and triple products, sums and rounding
// reset (rst, synchronous) clears only the stage valid bits, s_axis_tready low
// a stall on m_axis freezes every stage; s_axis_tready falls with it
// the sine table is a constant rom, one copy per angle lane with two reads
module euler_to_quaternion_top #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int FRACTION_BITS    = 14
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // pitch_angle [15:0], yaw_angle [30:16], roll_angle [46:31], zero [47]
  input  logic [e2q_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
  output logic [e2q_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import e2q_pkg::*;

  localparam int TW     = FRACTION_BITS + 1;
  localparam int KW     = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int NUM_W  = $clog2(IDX_DIVISOR * SINE_TABLE_DEPTH + IDX_ROUND + 1);
  localparam int MW     = NUM_W - IDX_PRE_SHIFT;
  localparam int RECIP_SHIFT = MW + $clog2(IDX_ODD_DIV);
  localparam logic [63:0] RECIP =
    ((64'd1 << RECIP_SHIFT) + 64'(IDX_ODD_DIV) - 64'd1) / 64'(IDX_ODD_DIV);
  localparam int RW     = $clog2(RECIP + 64'd1);
  localparam int PW     = MW + RW;
  localparam int TRW    = 2 * TW;
  localparam int SW     = TRW + 1;
  localparam int RND_W  = SW + 1;
  localparam int YAW_IDX_MAX = (SINE_TABLE_DEPTH + 1) / 2;

  localparam logic [63:0] STEP_WHOLE = HALF_PI_Q62 / 64'(SINE_TABLE_DEPTH);
  localparam logic [63:0] STEP_REST  = HALF_PI_Q62 % 64'(SINE_TABLE_DEPTH);
  localparam logic [63:0] ROM_ROUND  = 64'd1 << (Q_FRAC - 1 - FRACTION_BITS);

  localparam logic [2*TW-1:0]         PAIR_HALF  = (2*TW)'(1) << (FRACTION_BITS - 1);
  localparam logic signed [RND_W-1:0] ROUND_HALF = RND_W'(64'd1 << (FRACTION_BITS - 1));
  localparam logic signed [RND_W-1:0] QUAT_MAX   = RND_W'(32767);
  localparam logic signed [RND_W-1:0] QUAT_MIN   = -QUAT_MAX - RND_W'(1);

  // apply a sign to a product magnitude
  function automatic logic signed [TRW-1:0] apply_sign(input logic [TRW-1:0] m,
                                                       input logic n);
    return n ? -$signed(m) : $signed(m);
  endfunction

  // round to nearest, halves away from zero, then saturate
  function automatic logic [QUAT_W-1:0] round_sat(input logic signed [SW-1:0] s);
    logic signed [RND_W-1:0] s_ext;
    logic signed [RND_W-1:0] biased;
    logic signed [RND_W-1:0] shifted;
    s_ext   = RND_W'(s);
    biased  = s_ext + (s_ext[RND_W-1] ? ROUND_HALF - RND_W'(1) : ROUND_HALF);
    shifted = biased >>> FRACTION_BITS;
    if (shifted > QUAT_MAX) begin
      shifted = QUAT_MAX;
    end else if (shifted < QUAT_MIN) begin
      shifted = QUAT_MIN;
    end
    return shifted[QUAT_W-1:0];
  endfunction

  // sine rom, quarter wave, one copy per lane
  logic [TW-1:0] rom [NUM_LANES][SINE_TABLE_DEPTH+1];

  for (genvar e = 0; e <= SINE_TABLE_DEPTH; e++) begin : g_rom
    localparam logic [63:0] ENT_X =
      STEP_WHOLE * 64'(e) + (STEP_REST * 64'(e)) / 64'(SINE_TABLE_DEPTH);
    localparam logic [63:0] ENT_SIN = sine_q62(ENT_X);
    localparam logic [63:0] ENT_VAL = (ENT_SIN + ROM_ROUND) >> (Q_FRAC - FRACTION_BITS);
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_copy
      assign rom[l][e] = ENT_VAL[TW-1:0];
    end
  end

  // global advance: output register empty or being taken
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv && !rst;

  // stage valid bits
  logic v1, v2, v3, v4, v5, v6, v7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      v4            <= 1'b0;
      v5            <= 1'b0;
      v6            <= 1'b0;
      v7            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      v1            <= s_axis_tvalid;
      v2            <= v1;
      v3            <= v2;
      v4            <= v3;
      v5            <= v4;
      v6            <= v5;
      v7            <= v6;
      m_axis_tvalid <= v7;
    end
  end

  // stage 1: unpack, clamp, split into sign and magnitude
  logic signed [PITCH_W-1:0] pitch_in, pitch_c;
  logic signed [YAW_W-1:0]   yaw_in, yaw_c;
  logic signed [ROLL_W-1:0]  roll_in, roll_c;
  logic [PITCH_W-1:0]        pitch_abs;
  logic [YAW_W-1:0]          yaw_abs;
  logic [ROLL_W-1:0]         roll_abs;
  logic [MAG_W-1:0]          mag1_next [NUM_LANES];
  logic                      neg1_next [NUM_LANES];

  assign pitch_in = s_axis_tdata[PITCH_LSB +: PITCH_W];
  assign yaw_in   = s_axis_tdata[YAW_LSB +: YAW_W];
  assign roll_in  = s_axis_tdata[ROLL_LSB +: ROLL_W];

  always_comb begin
    pitch_c = pitch_in;
    if (pitch_in > $signed(PITCH_W'(PITCH_LIMIT))) begin
      pitch_c = PITCH_W'(PITCH_LIMIT);
    end else if (pitch_in < -$signed(PITCH_W'(PITCH_LIMIT))) begin
      pitch_c = -$signed(PITCH_W'(PITCH_LIMIT));
    end
    yaw_c = yaw_in;
    if (yaw_in > $signed(YAW_W'(YAW_LIMIT))) begin
      yaw_c = YAW_W'(YAW_LIMIT);
    end else if (yaw_in < -$signed(YAW_W'(YAW_LIMIT))) begin
      yaw_c = -$signed(YAW_W'(YAW_LIMIT));
    end
    roll_c = roll_in;
    if (roll_in > $signed(ROLL_W'(ROLL_LIMIT))) begin
      roll_c = ROLL_W'(ROLL_LIMIT);
    end else if (roll_in < -$signed(ROLL_W'(ROLL_LIMIT))) begin
      roll_c = -$signed(ROLL_W'(ROLL_LIMIT));
    end
    pitch_abs = pitch_c[PITCH_W-1] ? PITCH_W'(-pitch_c) : PITCH_W'(pitch_c);
    yaw_abs   = yaw_c[YAW_W-1]     ? YAW_W'(-yaw_c)     : YAW_W'(yaw_c);
    roll_abs  = roll_c[ROLL_W-1]   ? ROLL_W'(-roll_c)   : ROLL_W'(roll_c);
    mag1_next[LANE_X] = pitch_abs[MAG_W-1:0];
    mag1_next[LANE_Y] = yaw_abs[MAG_W-1:0];
    mag1_next[LANE_Z] = roll_abs[MAG_W-1:0];
    neg1_next[LANE_X] = pitch_c[PITCH_W-1];
    neg1_next[LANE_Y] = yaw_c[YAW_W-1];
    neg1_next[LANE_Z] = roll_c[ROLL_W-1];
  end

  logic [MAG_W-1:0] mag1 [NUM_LANES];
  logic             neg1 [NUM_LANES];
  logic [MW-1:0]    m2   [NUM_LANES];
  logic             neg2 [NUM_LANES];
  logic [KW-1:0]    k3   [NUM_LANES];
  logic             neg3 [NUM_LANES];
  logic [TW-1:0]    sin4 [NUM_LANES];
  logic [TW-1:0]    cos4 [NUM_LANES];
  logic             neg4 [NUM_LANES];
  logic [NUM_W-1:0] num2_next [NUM_LANES];
  logic [PW-1:0]    prod3 [NUM_LANES];
  logic [PW-1:0]    quo3  [NUM_LANES];

  // index arithmetic: scale, pre-shift, then reciprocal multiply
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      num2_next[l] = NUM_W'(mag1[l]) * NUM_W'(SINE_TABLE_DEPTH) + NUM_W'(IDX_ROUND);
      prod3[l]     = PW'(m2[l]) * PW'(RECIP);
      quo3[l]      = prod3[l] >> RECIP_SHIFT;
    end
  end

  // stages 1 to 4: per lane index and table lookup
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        mag1[l] <= mag1_next[l];
        neg1[l] <= neg1_next[l];
        m2[l]   <= num2_next[l][NUM_W-1:IDX_PRE_SHIFT];
        neg2[l] <= neg1[l];
        k3[l]   <= (quo3[l] > PW'(SINE_TABLE_DEPTH)) ? KW'(SINE_TABLE_DEPTH)
                                                     : quo3[l][KW-1:0];
        neg3[l] <= neg2[l];
        sin4[l] <= rom[l][k3[l]];
        cos4[l] <= rom[l][KW'(SINE_TABLE_DEPTH) - k3[l]];
        neg4[l] <= neg3[l];
      end
    end
  end

  // stage 5: pair products of the x and y factors, rounded
  logic [2*TW-1:0] pp_cc, pp_ss, pp_sc, pp_cs;
  logic [TW-1:0]   pair_cc, pair_ss, pair_sc, pair_cs;
  logic [TW-1:0]   cz5, sz5;
  logic            nx5, ny5, nz5;

  always_comb begin
    pp_cc = (2*TW)'(cos4[LANE_X]) * (2*TW)'(cos4[LANE_Y]) + PAIR_HALF;
    pp_ss = (2*TW)'(sin4[LANE_X]) * (2*TW)'(sin4[LANE_Y]) + PAIR_HALF;
    pp_sc = (2*TW)'(sin4[LANE_X]) * (2*TW)'(cos4[LANE_Y]) + PAIR_HALF;
    pp_cs = (2*TW)'(cos4[LANE_X]) * (2*TW)'(sin4[LANE_Y]) + PAIR_HALF;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pair_cc <= pp_cc[FRACTION_BITS +: TW];
      pair_ss <= pp_ss[FRACTION_BITS +: TW];
      pair_sc <= pp_sc[FRACTION_BITS +: TW];
      pair_cs <= pp_cs[FRACTION_BITS +: TW];
      cz5     <= cos4[LANE_Z];
      sz5     <= sin4[LANE_Z];
      nx5     <= neg4[LANE_X];
      ny5     <= neg4[LANE_Y];
      nz5     <= neg4[LANE_Z];
    end
  end

  // stage 6: eight signed triple products
  logic signed [TRW-1:0] t_ccc, t_sss, t_scc, t_css, t_csc, t_scs, t_ccs, t_ssc;

  always_ff @(posedge clk) begin
    if (adv) begin
      t_ccc <= apply_sign(TRW'(pair_cc) * TRW'(cz5), 1'b0);
      t_sss <= apply_sign(TRW'(pair_ss) * TRW'(sz5), nx5 ^ ny5 ^ nz5);
      t_scc <= apply_sign(TRW'(pair_sc) * TRW'(cz5), nx5);
      t_css <= apply_sign(TRW'(pair_cs) * TRW'(sz5), ny5 ^ nz5);
      t_csc <= apply_sign(TRW'(pair_cs) * TRW'(cz5), ny5);
      t_scs <= apply_sign(TRW'(pair_sc) * TRW'(sz5), nx5 ^ nz5);
      t_ccs <= apply_sign(TRW'(pair_cc) * TRW'(sz5), nz5);
      t_ssc <= apply_sign(TRW'(pair_ss) * TRW'(cz5), nx5 ^ ny5);
    end
  end

  // stage 7: component sums
  logic signed [SW-1:0] sum_w, sum_x, sum_y, sum_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_w <= SW'(t_ccc) - SW'(t_sss);
      sum_x <= SW'(t_scc) + SW'(t_css);
      sum_y <= SW'(t_csc) - SW'(t_scs);
      sum_z <= SW'(t_ccs) + SW'(t_ssc);
    end
  end

  // stage 8: round, saturate, output register
  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {round_sat(sum_z), round_sat(sum_y),
                       round_sat(sum_x), round_sat(sum_w)};
    end
  end

  // a valid pose moves from the table read into the pair stage
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (v4 && adv) |=> v5)
    else $error("pipeline dropped a pose between table read and pair stage");

  // a stalled stage keeps its pose
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (v6 && !adv) |=> v6)
    else $error("triple product stage lost a pose during a stall");

  // table index never runs past the quarter wave
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (k3[LANE_X] <= KW'(SINE_TABLE_DEPTH) && k3[LANE_Z] <= KW'(SINE_TABLE_DEPTH)))
    else $error("pitch or roll table index out of range");

  // clamped yaw reaches at most half of the table
  a_yaw_idx: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (k3[LANE_Y] <= KW'(YAW_IDX_MAX)))
    else $error("yaw table index beyond clamp range");

endmodule

// ===== verif/tb.sv =====
// tb: self-checking bench for euler_to_quaternion_top, directed poses then random
// ones, every output beat checked against a directed table value or a local
// fixed-point rotation model; depends on e2q_pkg and euler_to_quaternion_top
`timescale 1ns / 1ps

module tb;

  localparam int TABLE_DEPTH   = 1024;
  localparam int FRAC_BITS     = 14;
  localparam int PITCH_MAX     = 18000;
  localparam int YAW_MAX       = 9000;
  localparam int ROLL_MAX      = 18000;
  localparam int RANDOM_POSES  = 530;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int STALL_CYCLES  = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int IDLE_PERCENT  = 34;
  localparam logic [63:0] HALF_PI_FIX = 64'h6487ED5110B4611A;

  typedef struct packed {
    logic signed [15:0] pitch;
    logic signed [14:0] yaw;
    logic signed [15:0] roll;
  } pose_t;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    pose_t pose;
    bit    known;
    quat_t quat;
  } pose_row_t;

  logic                           clk;
  logic                           rst;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [e2q_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [e2q_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  int unsigned half_sine [0:TABLE_DEPTH];
  pose_row_t   directed_rows[$];
  quat_t       quat_pending[$];
  int          poses_sent;
  int          quats_checked  = 0;
  int          mismatch_count = 0;
  int          cycle_count    = 0;

  euler_to_quaternion_top #(
    .SINE_TABLE_DEPTH (TABLE_DEPTH),
    .FRACTION_BITS    (FRAC_BITS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock and reset
  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  initial begin
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // unsigned Q2.62 product, truncated
  function automatic logic [63:0] fix62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // quarter-wave sine table from a taylor series, rounded to FRAC_BITS
  function automatic void build_half_sine();
    logic [63:0] step_whole;
    logic [63:0] step_rest;
    logic [63:0] arg;
    logic [63:0] arg_sq;
    logic [63:0] term;
    logic [63:0] acc;
    step_whole = HALF_PI_FIX / TABLE_DEPTH;
    step_rest  = HALF_PI_FIX % TABLE_DEPTH;
    for (int k = 0; k <= TABLE_DEPTH; k++) begin
      arg    = step_whole * 64'(k) + (step_rest * 64'(k)) / TABLE_DEPTH;
      arg_sq = fix62_mul(arg, arg);
      term   = arg;
      acc    = arg;
      for (int n = 1; n <= 10; n++) begin
        term = fix62_mul(term, arg_sq) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      acc = (acc + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
      half_sine[k] = acc[31:0];
    end
  endfunction

  function automatic int clamp_angle(input int a, input int lim);
    if (a > lim) return lim;
    if (a < -lim) return -lim;
    return a;
  endfunction

  // signed sine and non-negative cosine of half the angle
  function automatic void half_angle_trig(input int a, output longint s, output longint c);
    int k;
    k = ((a < 0 ? -a : a) * TABLE_DEPTH + 9000) / 18000;
    if (k > TABLE_DEPTH) k = TABLE_DEPTH;
    s = a < 0 ? -longint'(half_sine[k]) : longint'(half_sine[k]);
    c = longint'(half_sine[TABLE_DEPTH - k]);
  endfunction

  // (a*b rounded to FRAC_BITS) * c, magnitude rounding, sign reapplied
  function automatic longint triple_product(input longint a, input longint b,
                                            input longint c);
    longint ab;
    longint mag;
    bit     neg;
    neg = (a < 0) ^ (b < 0) ^ (c < 0);
    ab  = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + (longint'(1) << (FRAC_BITS - 1)))
          >>> FRAC_BITS;
    mag = ab * (c < 0 ? -c : c);
    return neg ? -mag : mag;
  endfunction

  // round to nearest, halves away from zero, then saturate
  function automatic logic signed [15:0] round_component(input longint acc);
    longint half;
    longint r;
    half = longint'(1) << (FRAC_BITS - 1);
    if (acc >= 0) begin
      r = (acc + half) >>> FRAC_BITS;
    end else begin
      r = -((-acc + half) >>> FRAC_BITS);
    end
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // qx * qy * qz for one pose
  function automatic quat_t pose_to_quat(input pose_t pose);
    longint sx, cx, sy, cy, sz, cz;
    quat_t  q;
    half_angle_trig(clamp_angle(int'($signed(pose.pitch)), PITCH_MAX), sx, cx);
    half_angle_trig(clamp_angle(int'($signed(pose.yaw)), YAW_MAX), sy, cy);
    half_angle_trig(clamp_angle(int'($signed(pose.roll)), ROLL_MAX), sz, cz);
    q.w = round_component(triple_product(cx, cy, cz) - triple_product(sx, sy, sz));
    q.x = round_component(triple_product(sx, cy, cz) + triple_product(cx, sy, sz));
    q.y = round_component(triple_product(cx, sy, cz) - triple_product(sx, cy, sz));
    q.z = round_component(triple_product(cx, cy, sz) + triple_product(sx, sy, cz));
    return q;
  endfunction

  function automatic pose_row_t make_row(input int p, input int yw, input int r,
                                         input bit known, input int w, input int x,
                                         input int y, input int z);
    pose_row_t row;
    row.pose.pitch = p[15:0];
    row.pose.yaw   = yw[14:0];
    row.pose.roll  = r[15:0];
    row.known      = known;
    row.quat.w     = w[15:0];
    row.quat.x     = x[15:0];
    row.quat.y     = y[15:0];
    row.quat.z     = z[15:0];
    return row;
  endfunction

  // mostly in range, some at the clamp edges or near zero, rest over the full width
  function automatic int pick_angle(input int lim, input int width);
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return int'($urandom_range(2 * lim)) - lim;
    if (sel < 72) return ($urandom_range(1) ? lim : -lim) + int'($urandom_range(6)) - 3;
    if (sel < 77) return int'($urandom_range(40)) - 20;
    return int'($urandom_range((1 << width) - 1)) - (1 << (width - 1));
  endfunction

  function automatic bit quiet_window();
    return poses_sent >= 150 && poses_sent < 260;
  endfunction

  // directed poses: zero, half turns, clamp edges and a few corners
  initial begin
    build_half_sine();
    directed_rows.push_back(make_row(     0,      0,      0, 1, 16384,      0, 0,      0));
    directed_rows.push_back(make_row( 18000,      0,      0, 1,     0,  16384, 0,      0));
    directed_rows.push_back(make_row(-18000,      0,      0, 1,     0, -16384, 0,      0));
    directed_rows.push_back(make_row( 32767,      0,      0, 1,     0,  16384, 0,      0));
    directed_rows.push_back(make_row(-32768,      0,      0, 1,     0, -16384, 0,      0));
    directed_rows.push_back(make_row(     0,      0,  18000, 1,     0,      0, 0,  16384));
    directed_rows.push_back(make_row(     0,      0, -18000, 1,     0,      0, 0, -16384));
    directed_rows.push_back(make_row(     0,      0,  32767, 1,     0,      0, 0,  16384));
    directed_rows.push_back(make_row(     0,      0, -32768, 1,     0,      0, 0, -16384));
    directed_rows.push_back(make_row(     0,   9000,      0, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(     0,  -9000,      0, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(     0,  16383,      0, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(     0, -16384,      0, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row( 18000,   9000,  18000, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(-18000,  -9000, -18000, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row( 32767,  16383,  32767, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(-32768, -16384, -32768, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(     1,      1,      1, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(    -1,     -1,     -1, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(     9,     -9,      9, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row( 17999,   8999, -17999, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row( 18001,   9001, -18001, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(  4500,  -4500,   9000, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row( -9000,   4500,  -4500, 0, 0, 0, 0, 0));
  end

  // pose source: directed table first, then random poses, with random gaps
  initial begin : pose_source
    pose_row_t row;
    int        total;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    poses_sent     = 0;
    wait (!rst);
    @(posedge clk);
    total = directed_rows.size() + RANDOM_POSES;
    for (int i = 0; i < total; i++) begin
      if (i < directed_rows.size()) begin
        row = directed_rows[i];
      end else begin
        row = make_row(pick_angle(PITCH_MAX, 16), pick_angle(YAW_MAX, 15),
                       pick_angle(ROLL_MAX, 16), 0, 0, 0, 0, 0);
      end
      while (!quiet_window() && $urandom_range(99) < IDLE_PERCENT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {1'b0, row.pose.roll, row.pose.yaw, row.pose.pitch};
      do @(posedge clk); while (!s_axis_tready);
      quat_pending.push_back(row.known ? row.quat : pose_to_quat(row.pose));
      poses_sent++;
    end
    s_axis_tvalid <= 1'b0;

    // drain, then let the pipeline settle
    while (quat_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d poses sent (%0d directed, clamp edges and full-width noise included)",
             poses_sent, directed_rows.size());
    $display("%0d quaternions checked, %0d-cycle output stall, %0d mismatches",
             quats_checked, STALL_CYCLES, mismatch_count);
    if (mismatch_count == 0 && quat_pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // output ready: random stalls, a quiet window, and one long hold-off
  initial begin : quat_sink
    bit held;
    held = 1'b0;
    m_axis_tready <= 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!held && poses_sent >= 400) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end
      m_axis_tready <= quiet_window() || $urandom_range(99) >= IDLE_PERCENT;
    end
  end

  function automatic void compare_field(input string name, input logic signed [15:0] want,
                                        input logic signed [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // output beat check against the oldest pending quaternion
  always @(posedge clk) begin : quat_check
    quat_t got;
    quat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.w = m_axis_tdata[15:0];
      got.x = m_axis_tdata[31:16];
      got.y = m_axis_tdata[47:32];
      got.z = m_axis_tdata[63:48];
      if (quat_pending.size() == 0) begin
        $error("quaternion beat with none pending: w %0d x %0d y %0d z %0d",
               got.w, got.x, got.y, got.z);
        mismatch_count++;
      end else begin
        want = quat_pending.pop_front();
        compare_field("quat_w", want.w, got.w);
        compare_field("quat_x", want.x, got.x);
        compare_field("quat_y", want.y, got.y);
        compare_field("quat_z", want.z, got.z);
        quats_checked++;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

// ===== files.f =====
src/e2q_pkg.sv
src/euler_to_quaternion_top.sv
verif/tb.sv
